>>> hw/rtl/diee_pkg.sv
// ----------------------------------------------------------------------------
// diee_pkg: shared definitions of the delayed interval event emitter
// Widths, register indexes and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package diee_pkg;

   // Default values of the top level parameters.
   localparam int MAX_EMITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   // Fixed widths of the port fields.
   localparam int DATA_BITS      = 32;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_DELAY    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIFE_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIFE_UNLIMITED = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMIT_TOTAL     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMIT_UNLIMITED = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMIT_INTERVAL  = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // latch the elapsed time of a new beat
      logic do_delay;   // count down the start delay, form the pass time
      logic do_life;    // advance the lifetime accumulator
      logic do_credit;  // compare pass time with the emit credit
      logic do_emit;    // load one emit event and advance the burst
      logic do_status;  // load the status-only result
      logic div_start;  // launch the remainder unit for the credit
      logic mod_fix;    // write the credit from the remainder unit
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic active;     // delay is over for this beat
      logic emit_go;    // emission enabled and the credit is used up
      logic last;       // the event presented now ends the burst
      logic cap_div;    // burst ends on the per-beat cap with a nonzero interval
      logic out_free;   // result register can take a new beat
      logic div_done;   // remainder unit has its answer
   } sts_type;

endpackage

>>> hw/rtl/diee_rem_unit.sv
// ----------------------------------------------------------------------------
// diee_rem_unit: iterative remainder unit
// Restoring division, one quotient bit per cycle. Gives the distance from
// the dividend to the next multiple of the divisor (divisor - remainder).
// ----------------------------------------------------------------------------
module diee_rem_unit #(
   parameter int TIME_BITS = diee_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] dividend,
   input  logic [TIME_BITS-1:0] divisor,
   output logic                 done,
   output logic [TIME_BITS-1:0] gap
);

   localparam int CW = $clog2(TIME_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [TIME_BITS-1:0] dvs_ff, dvs_in;

   logic [TIME_BITS:0]   trial;
   logic [TIME_BITS:0]   diff;

   assign trial = {rem_ff, quo_ff[TIME_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(TIME_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so the trial fits.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[TIME_BITS-1:0];
         end else begin
            rem_in = trial[TIME_BITS-1:0];
         end
         quo_in = {quo_ff[TIME_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign gap  = dvs_ff - rem_ff;

endmodule

>>> hw/rtl/diee_datapath.sv
// ----------------------------------------------------------------------------
// diee_datapath: registers and arithmetic of the emitter
// Holds the configuration, the delay, lifetime, credit and count state,
// the per-beat work registers and the result register.
// ----------------------------------------------------------------------------
module diee_datapath #(
   parameter int MAX_EMITS = diee_pkg::MAX_EMITS_DEFAULT,
   parameter int TIME_BITS = diee_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  diee_pkg::cmd_type                   cmd,
   output diee_pkg::sts_type                   sts,
   input  logic [diee_pkg::DATA_BITS-1:0]      req_elapsed,
   input  logic                                csr_valid,
   input  logic [diee_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [diee_pkg::DATA_BITS-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_emit,
   output logic [diee_pkg::DATA_BITS-1:0]      rsp_over_time,
   output logic                                rsp_is_last,
   output logic                                rsp_finished
);

   localparam int W   = TIME_BITS;
   localparam int DB  = diee_pkg::DATA_BITS;
   localparam int CB  = diee_pkg::COUNT_BITS;
   localparam int EXT = (TIME_BITS > DB) ? TIME_BITS : DB;
   localparam int NW  = $clog2(MAX_EMITS + 1);

   // Clamp a field value to the largest time value.
   function automatic logic [W-1:0] sat_time(input logic [DB-1:0] v);
      logic [EXT-1:0] ext;
      logic [EXT-1:0] lim;
      ext = EXT'(v);
      lim = EXT'({W{1'b1}});
      if (ext > lim) begin
         sat_time = '1;
      end else begin
         sat_time = ext[W-1:0];
      end
   endfunction

   // Configuration.
   logic [W-1:0]  delay_cfg_ff, delay_cfg_in;
   logic [W-1:0]  limit_cfg_ff, limit_cfg_in;
   logic          life_unl_ff, life_unl_in;
   logic          emit_unl_ff, emit_unl_in;
   logic [W-1:0]  ival_cfg_ff, ival_cfg_in;

   // Emitter state.
   logic [W-1:0]  delay_el_ff, delay_el_in;
   logic [W-1:0]  life_el_ff, life_el_in;
   logic [W-1:0]  credit_ff, credit_in;
   logic [CB-1:0] count_ff, count_in;

   // Per-beat work registers.
   logic [W-1:0]  elapsed_ff, elapsed_in;
   logic [W-1:0]  pass_ff, pass_in;
   logic          active_ff, active_in;
   logic          fin_ff, fin_in;
   logic [W-1:0]  over_ff, over_in;
   logic [NW-1:0] n_ff, n_in;

   // Result register.
   logic          out_valid_ff, out_valid_in;
   logic          out_emit_ff, out_emit_in;
   logic [DB-1:0] out_over_ff, out_over_in;
   logic          out_last_ff, out_last_in;
   logic          out_fin_ff, out_fin_in;

   // Delay step.
   logic [W:0]    dsum, dsub;
   logic          below, dge;
   // Lifetime step.
   logic [W:0]    lsum;
   logic [W-1:0]  lsat;
   // Credit and burst step.
   logic          emit_en, pass_ge;
   logic          cnt_exh, over_lt, n_hit, last_now;
   logic [W-1:0]  over_sub, gap_sub;
   logic [EXT-1:0] over_ext;
   logic          rem_done;
   logic [W-1:0]  rem_gap;

   assign below = delay_el_ff < delay_cfg_ff;
   assign dsum  = {1'b0, delay_el_ff} + {1'b0, elapsed_ff};
   assign dge   = dsum >= {1'b0, delay_cfg_ff};
   assign dsub  = dsum - {1'b0, delay_cfg_ff};

   assign lsum = {1'b0, life_el_ff} + {1'b0, pass_ff};
   assign lsat = lsum[W] ? {W{1'b1}} : lsum[W-1:0];

   assign emit_en  = emit_unl_ff || (count_ff != '0);
   assign pass_ge  = pass_ff >= credit_ff;

   assign cnt_exh  = !emit_unl_ff && (count_ff == CB'(1));
   assign over_lt  = over_ff < ival_cfg_ff;
   assign n_hit    = (n_ff + NW'(1)) == NW'(MAX_EMITS);
   assign last_now = cnt_exh || over_lt || n_hit;
   assign over_sub = over_ff - ival_cfg_ff;
   assign gap_sub  = ival_cfg_ff - over_ff;
   assign over_ext = EXT'(over_ff);

   diee_rem_unit #(
      .TIME_BITS(TIME_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (over_sub),
      .divisor  (ival_cfg_ff),
      .done     (rem_done),
      .gap      (rem_gap)
   );

   always_comb begin
      sts.active   = active_ff;
      sts.emit_go  = emit_en && pass_ge;
      sts.last     = last_now;
      sts.cap_div  = !cnt_exh && !over_lt && (ival_cfg_ff != '0);
      sts.out_free = !out_valid_ff || rsp_ready;
      sts.div_done = rem_done;
   end

   always_comb begin
      delay_cfg_in = delay_cfg_ff;
      limit_cfg_in = limit_cfg_ff;
      life_unl_in  = life_unl_ff;
      emit_unl_in  = emit_unl_ff;
      ival_cfg_in  = ival_cfg_ff;
      delay_el_in  = delay_el_ff;
      life_el_in   = life_el_ff;
      credit_in    = credit_ff;
      count_in     = count_ff;
      elapsed_in   = elapsed_ff;
      pass_in      = pass_ff;
      active_in    = active_ff;
      fin_in       = fin_ff;
      over_in      = over_ff;
      n_in         = n_ff;
      out_emit_in  = out_emit_ff;
      out_over_in  = out_over_ff;
      out_last_in  = out_last_ff;
      out_fin_in   = out_fin_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.accept) begin
         elapsed_in = sat_time(req_elapsed);
      end

      if (cmd.do_delay) begin
         fin_in = 1'b0;
         if (below) begin
            active_in = dge;
            pass_in   = dsub[W-1:0];
            if (dge) begin
               delay_el_in = delay_cfg_ff;
            end else begin
               delay_el_in = dsum[W-1:0];
            end
         end else begin
            active_in = 1'b1;
            pass_in   = elapsed_ff;
         end
      end

      if (cmd.do_life) begin
         if (!life_unl_ff && (lsat > limit_cfg_ff)) begin
            life_el_in = limit_cfg_ff;
         end else begin
            life_el_in = lsat;
         end
      end

      if (cmd.do_credit) begin
         fin_in = !life_unl_ff && (life_el_ff >= limit_cfg_ff);
         over_in = pass_ff - credit_ff;
         n_in    = '0;
         if (emit_en && !pass_ge) begin
            credit_in = credit_ff - pass_ff;
         end
      end

      if (cmd.do_emit) begin
         out_valid_in = 1'b1;
         out_emit_in  = 1'b1;
         out_over_in  = over_ext[DB-1:0];
         out_last_in  = last_now;
         out_fin_in   = last_now && fin_ff;
         n_in         = n_ff + NW'(1);
         over_in      = over_sub;
         if (!emit_unl_ff) begin
            count_in = count_ff - CB'(1);
         end
         // Count exhaustion wins over the interval test, which wins over the cap.
         if (cnt_exh) begin
            credit_in = over_ff;
         end else if (over_lt) begin
            credit_in = gap_sub;
         end else if (n_hit) begin
            credit_in = '0;
         end
      end

      if (cmd.do_status) begin
         out_valid_in = 1'b1;
         out_emit_in  = 1'b0;
         out_over_in  = '0;
         out_last_in  = 1'b1;
         out_fin_in   = fin_ff;
      end

      if (cmd.mod_fix) begin
         credit_in = rem_gap;
      end

      if (csr_valid) begin
         unique case (csr_index)
            diee_pkg::CSR_START_DELAY:    delay_cfg_in = sat_time(csr_wdata);
            diee_pkg::CSR_LIFE_LIMIT:     limit_cfg_in = sat_time(csr_wdata);
            diee_pkg::CSR_LIFE_UNLIMITED: life_unl_in  = csr_wdata[0];
            diee_pkg::CSR_EMIT_TOTAL:     count_in     = csr_wdata[CB-1:0];
            diee_pkg::CSR_EMIT_UNLIMITED: emit_unl_in  = csr_wdata[0];
            diee_pkg::CSR_EMIT_INTERVAL:  ival_cfg_in  = sat_time(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_cfg_ff <= '0;
         limit_cfg_ff <= '0;
         life_unl_ff  <= 1'b1;
         emit_unl_ff  <= 1'b0;
         ival_cfg_ff  <= '0;
         delay_el_ff  <= '0;
         life_el_ff   <= '0;
         credit_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         delay_cfg_ff <= delay_cfg_in;
         limit_cfg_ff <= limit_cfg_in;
         life_unl_ff  <= life_unl_in;
         emit_unl_ff  <= emit_unl_in;
         ival_cfg_ff  <= ival_cfg_in;
         delay_el_ff  <= delay_el_in;
         life_el_ff   <= life_el_in;
         credit_ff    <= credit_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      pass_ff     <= pass_in;
      active_ff   <= active_in;
      fin_ff      <= fin_in;
      over_ff     <= over_in;
      n_ff        <= n_in;
      out_emit_ff <= out_emit_in;
      out_over_ff <= out_over_in;
      out_last_ff <= out_last_in;
      out_fin_ff  <= out_fin_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_is_emit   = out_emit_ff;
   assign rsp_over_time = out_over_ff;
   assign rsp_is_last   = out_last_ff;
   assign rsp_finished  = out_fin_ff;

endmodule

>>> hw/rtl/diee_ctrl.sv
// ----------------------------------------------------------------------------
// diee_ctrl: sequencer of the emitter
// Walks each beat through delay and, when active, lifetime and credit
// steps, then the burst or status; a capped burst waits on the remainder unit.
// ----------------------------------------------------------------------------
module diee_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output diee_pkg::cmd_type cmd,
   input  diee_pkg::sts_type sts
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DELAY  = 7'b0000010,
      ST_LIFE   = 7'b0000100,
      ST_CREDIT = 7'b0001000,
      ST_EMIT   = 7'b0010000,
      ST_STATUS = 7'b0100000,
      ST_DIV    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_DELAY;
            end
         end
         ST_DELAY: begin
            cmd.do_delay = 1'b1;
            state_in     = ST_LIFE;
         end
         ST_LIFE: begin
            if (sts.active) begin
               cmd.do_life = 1'b1;
               state_in    = ST_CREDIT;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_CREDIT: begin
            cmd.do_credit = 1'b1;
            state_in      = sts.emit_go ? ST_EMIT : ST_STATUS;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.do_emit = 1'b1;
               if (sts.last) begin
                  if (sts.cap_div) begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_STATUS: begin
            if (sts.out_free) begin
               cmd.do_status = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.mod_fix = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

>>> hw/rtl/delayed_interval_event_emitter_top.sv
// ----------------------------------------------------------------------------
// delayed_interval_event_emitter_top: timed emitter with start delay
// Counts down a start delay, runs a lifetime and gives emit events at a
// fixed interval, several per update, each with its overrun time.
// ----------------------------------------------------------------------------
// Each request beat carries the ticks elapsed since the previous update and
// is answered by one or more response beats: a burst of emit events, or a
// single status-only beat, the final one marked is_last and carrying the
// finished flag. A beat is taken when the block is idle. The accept, delay
// countdown and, once the delay is over, the lifetime update and credit
// compare run in turn as states of the sequencer, before the state that
// loads the first response. Each response beat is loaded as soon as the
// result register is free, so a stalled consumer holds the burst back.
// When a burst is cut off by the MAX_EMITS cap with a nonzero interval,
// the credit to the next interval boundary comes from a bit-serial
// remainder unit, which must finish before the next request is taken;
// that unit sets the worst case. Responses sit in an output register, so
// the block carries on with its work while the last beat waits to be
// taken. The configuration port always accepts a write; writing
// emit_total also reloads the remaining event count. Time values are
// clamped to TIME_BITS bits.
// ----------------------------------------------------------------------------
module delayed_interval_event_emitter_top #(
   parameter int MAX_EMITS = diee_pkg::MAX_EMITS_DEFAULT,
   parameter int TIME_BITS = diee_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel: one update per beat.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [diee_pkg::DATA_BITS-1:0]      req_elapsed,
   // Response channel: events and status.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_is_emit,
   output logic [diee_pkg::DATA_BITS-1:0]      rsp_over_time,
   output logic                                rsp_is_last,
   output logic                                rsp_finished,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [diee_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [diee_pkg::DATA_BITS-1:0]      csr_wdata
);

   diee_pkg::cmd_type cmd;
   diee_pkg::sts_type sts;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   diee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   diee_datapath #(
      .MAX_EMITS(MAX_EMITS),
      .TIME_BITS(TIME_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_elapsed   (req_elapsed),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_emit   (rsp_is_emit),
      .rsp_over_time (rsp_over_time),
      .rsp_is_last   (rsp_is_last),
      .rsp_finished  (rsp_finished)
   );

`ifndef ASSERT_OFF
   // Only one update is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an update is in work");

   // A new response never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_emit || cmd.do_status) |-> sts.out_free)
      else $error("response register overwritten");

   // The remainder unit is launched only with the final event of a burst.
   a_div_with_last: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (cmd.do_emit && sts.last))
      else $error("remainder unit started outside the end of a burst");

   // Only emit events precede the final beat, and they never carry finished.
   a_mid_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_last) |-> (rsp_is_emit && !rsp_finished))
      else $error("malformed response ahead of the final beat");
`endif

endmodule

>>> verif/tb_delayed_interval_event_emitter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delayed_interval_event_emitter_top: self-checking bench of the emitter
// A queue-fed driver offers update beats and a clocked monitor checks every
// response beat against an in-bench model of delay, lifetime and emission,
// across directed corner cases and randomized configurations and idling.
// ----------------------------------------------------------------------------
module tb_delayed_interval_event_emitter_top;

   localparam int MAX_EMITS     = diee_pkg::MAX_EMITS_DEFAULT;
   localparam int TIME_BITS     = diee_pkg::TIME_BITS_DEFAULT;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 2 * TIME_BITS + 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 19;
   localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

   // Idling patterns of the two channels.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One response beat as the block should present it.
   typedef struct packed {
      logic        is_emit;
      logic [31:0] over_time;
      logic        is_last;
      logic        finished;
   } emit_beat_type;

   // Block ports. Every input starts at a known value.
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [diee_pkg::DATA_BITS-1:0]      req_elapsed = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_is_emit;
   logic [diee_pkg::DATA_BITS-1:0]      rsp_over_time;
   logic                                rsp_is_last;
   logic                                rsp_finished;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [diee_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [diee_pkg::DATA_BITS-1:0]      csr_wdata = '0;

   // Mirror of the configuration registers, at their reset values.
   logic [31:0] cfg_start_delay    = '0;
   logic [31:0] cfg_life_limit     = '0;
   logic        cfg_life_unlimited = 1'b1;
   logic        cfg_emit_unlimited = 1'b0;
   logic [31:0] cfg_emit_interval  = '0;

   // Mirror of the emitter state.
   logic [31:0] delay_count = '0;
   logic [31:0] life_count  = '0;
   logic [31:0] credit      = '0;
   logic [15:0] count_left  = '0;

   // Stimulus and checking bookkeeping.
   logic [31:0]   pending_elapsed[$];
   emit_beat_type due_beats[$];
   emit_beat_type want;
   logic [31:0]   next_elapsed;
   idle_mode_type idle_mode = IDLE_NONE;
   logic          req_took = 1'b0;
   int            hold_asks = 0;
   int            hold_seen = 0;
   int            hold_left = 0;
   int            cycle_count = 0;
   int            fail_count = 0;
   int            updates_taken = 0;
   int            beats_checked = 0;
   int            emit_beats = 0;
   int            finished_beats = 0;
   int            settings_used = 0;

   delayed_interval_event_emitter_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_elapsed   (req_elapsed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_emit   (rsp_is_emit),
      .rsp_over_time (rsp_over_time),
      .rsp_is_last   (rsp_is_last),
      .rsp_finished  (rsp_finished),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the emitter model by one update and queue the beats it causes.
   // The start delay is consumed first; only the overshoot ("pass") feeds the
   // lifetime and the emit credit. A burst ends on the count running out, on
   // the credit covering the remaining overrun, or on the per-update cap.
   function automatic void advance_emitter(input logic [31:0] elapsed);
      logic [63:0]   e;
      logic [63:0]   pass;
      logic [63:0]   rem;
      logic [63:0]   over;
      logic [63:0]   iv;
      logic [63:0]   sum;
      logic          active;
      logic          fin;
      int            n;
      emit_beat_type beat;
      e    = {32'b0, elapsed};
      pass = '0;
      fin  = 1'b0;
      n    = 0;
      if (delay_count < cfg_start_delay) begin
         rem = {32'b0, cfg_start_delay} - {32'b0, delay_count};
         if (e >= rem) begin
            pass        = e - rem;
            delay_count = cfg_start_delay;
            active      = 1'b1;
         end else begin
            delay_count = delay_count + elapsed;
            active      = 1'b0;
         end
      end else begin
         pass   = e;
         active = 1'b1;
      end

      if (active) begin
         // Lifetime saturates at the time range, then clamps to the limit.
         sum = {32'b0, life_count} + pass;
         if (sum > {32'b0, TMAX}) sum = {32'b0, TMAX};
         if (!cfg_life_unlimited && sum > {32'b0, cfg_life_limit})
            sum = {32'b0, cfg_life_limit};
         life_count = sum[31:0];

         if (cfg_emit_unlimited || count_left != 0) begin
            if (pass >= {32'b0, credit}) begin
               over = pass - {32'b0, credit};
               iv   = {32'b0, cfg_emit_interval};
               while (1) begin
                  beat = '{is_emit: 1'b1, over_time: over[31:0], is_last: 1'b0,
                           finished: 1'b0};
                  due_beats.push_back(beat);
                  n++;
                  if (!cfg_emit_unlimited) begin
                     count_left = count_left - 16'd1;
                     if (count_left == 0) begin
                        credit = over[31:0];
                        break;
                     end
                  end
                  if (over < iv) begin
                     credit = iv[31:0] - over[31:0];
                     break;
                  end
                  over = over - iv;
                  if (n >= MAX_EMITS) begin
                     // Dropped events leave the credit at the next boundary.
                     credit = (iv == 0) ? 32'd0 : iv[31:0] - (over % iv);
                     break;
                  end
               end
            end else begin
               credit = credit - pass[31:0];
            end
         end
         fin = !cfg_life_unlimited && life_count >= cfg_life_limit;
      end

      if (n == 0) begin
         beat = '{is_emit: 1'b0, over_time: 32'd0, is_last: 1'b1, finished: fin};
      end else begin
         beat          = due_beats.pop_back();
         beat.is_last  = 1'b1;
         beat.finished = fin;
      end
      due_beats.push_back(beat);
   endfunction

   // Percentage of cycles in which one side idles under the current pattern.
   function automatic int idle_pct(input idle_mode_type mode, input bit receiver);
      case (mode)
         IDLE_SENDER:   return receiver ? 0 : 75;
         IDLE_RECEIVER: return receiver ? 75 : 0;
         IDLE_BOTH:     return 11;
         default:       return 0;
      endcase
   endfunction

   // Saturating base plus a random step, used to place the delay and the
   // lifetime limit close to where the model state currently stands.
   function automatic logic [31:0] grow_from(input logic [31:0] base, input int span);
      logic [32:0] s;
      s = {1'b0, base} + 33'($urandom_range(span));
      return s[32] ? TMAX : s[31:0];
   endfunction

   // Elapsed times mostly scale with the interval so that bursts, count
   // exhaustion and the per-update cap all come up; the rest is noise.
   function automatic logic [31:0] pick_elapsed();
      logic [63:0] span;
      case ($urandom_range(9))
         0:       return $urandom();
         1:       return ($urandom_range(1) != 0) ? TMAX : 32'd0;
         2:       return 32'($urandom_range(3));
         default: begin
            span = (cfg_emit_interval == 0) ? 64'd64 : {32'b0, cfg_emit_interval};
            span = span * $urandom_range(1, 20);
            if (span > {32'b0, TMAX}) span = {32'b0, TMAX};
            return $urandom_range(span[31:0]);
         end
      endcase
   endfunction

   // Write one register and mirror it once the beat is taken.
   task automatic write_csr(input logic [diee_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         diee_pkg::CSR_START_DELAY:    cfg_start_delay = data;
         diee_pkg::CSR_LIFE_LIMIT:     cfg_life_limit = data;
         diee_pkg::CSR_LIFE_UNLIMITED: cfg_life_unlimited = data[0];
         diee_pkg::CSR_EMIT_TOTAL:     count_left = data[15:0];
         diee_pkg::CSR_EMIT_UNLIMITED: cfg_emit_unlimited = data[0];
         diee_pkg::CSR_EMIT_INTERVAL:  cfg_emit_interval = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_setting(input logic [31:0] delay, input logic [31:0] limit,
                                input logic life_unl, input logic [15:0] total,
                                input logic emit_unl, input logic [31:0] interval);
      write_csr(diee_pkg::CSR_START_DELAY, delay);
      write_csr(diee_pkg::CSR_LIFE_LIMIT, limit);
      write_csr(diee_pkg::CSR_LIFE_UNLIMITED, {31'b0, life_unl});
      write_csr(diee_pkg::CSR_EMIT_TOTAL, {16'b0, total});
      write_csr(diee_pkg::CSR_EMIT_UNLIMITED, {31'b0, emit_unl});
      write_csr(diee_pkg::CSR_EMIT_INTERVAL, interval);
      settings_used++;
   endtask

   // Wait until every queued update is taken and answered, then give the
   // remainder unit time to finish before the registers may change.
   task automatic drain();
      while (pending_elapsed.size() != 0 || req_valid || due_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver. A new beat is only loaded once the previous one has
   // been taken, so valid and the payload stay put while the block stalls.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_elapsed.size() != 0 &&
             $urandom_range(99) >= idle_pct(idle_mode, 1'b0)) begin
            next_elapsed = pending_elapsed.pop_front();
            req_valid   <= 1'b1;
            req_elapsed <= next_elapsed;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready. A long hold-off, when asked for, is counted here so the
   // output register fills and the block backs up onto its request side.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_asks;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b1));
      end
   end

   // Monitor. Handshakes are sampled at the rising edge, where the inputs
   // have been stable since the falling edge before it.
   always @(posedge clock) begin
      req_took = !reset && req_valid && req_ready;
      if (req_took) begin
         advance_emitter(req_elapsed);
         updates_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_beats.size() == 0) begin
            $error("response beat with nothing expected: is_emit %0d over_time %0d",
                   rsp_is_emit, rsp_over_time);
            fail_count++;
         end else begin
            want = due_beats.pop_front();
            if (rsp_is_emit !== want.is_emit) begin
               $error("is_emit: expected %0d, actual %0d", want.is_emit, rsp_is_emit);
               fail_count++;
            end
            if (rsp_over_time !== want.over_time) begin
               $error("over_time: expected %0d, actual %0d", want.over_time,
                      rsp_over_time);
               fail_count++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last: expected %0d, actual %0d", want.is_last, rsp_is_last);
               fail_count++;
            end
            if (rsp_finished !== want.finished) begin
               $error("finished: expected %0d, actual %0d", want.finished,
                      rsp_finished);
               fail_count++;
            end
            beats_checked++;
            if (want.is_emit) emit_beats++;
            if (want.finished) finished_beats++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int p;
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, no idling. At reset values the lifetime is unlimited
      // and the event budget is zero: only status beats come back, and the
      // largest elapsed time drives the lifetime into saturation.
      idle_mode = IDLE_NONE;
      pending_elapsed.push_back(32'd0);
      pending_elapsed.push_back(TMAX);
      drain();

      // Delay reached exactly: the update that ends the delay passes zero
      // time, and the empty credit still gives one event aged zero.
      write_setting(32'd100, TMAX, 1'b1, 16'd0, 1'b1, 32'd50);
      pending_elapsed.push_back(32'd60);
      pending_elapsed.push_back(32'd40);
      pending_elapsed.push_back(32'd49);
      pending_elapsed.push_back(32'd1);
      pending_elapsed.push_back(32'd175);
      drain();

      // Delay lowered below what has been counted, and the lifetime limit
      // lowered below what has been accumulated: the next update clamps it.
      write_csr(diee_pkg::CSR_START_DELAY, 32'd10);
      write_csr(diee_pkg::CSR_LIFE_LIMIT, 32'd5);
      write_csr(diee_pkg::CSR_LIFE_UNLIMITED, 32'd0);
      pending_elapsed.push_back(32'd25);
      pending_elapsed.push_back(32'd0);
      drain();

      // Count exhausted in the middle of a burst, then a spent budget.
      write_csr(diee_pkg::CSR_LIFE_UNLIMITED, 32'd1);
      write_csr(diee_pkg::CSR_EMIT_UNLIMITED, 32'd0);
      write_csr(diee_pkg::CSR_EMIT_TOTAL, 32'd3);
      write_csr(diee_pkg::CSR_EMIT_INTERVAL, 32'd10);
      pending_elapsed.push_back(32'd1000);
      pending_elapsed.push_back(32'd500);
      drain();

      // Per-update cap with a nonzero interval: the credit comes from the
      // remainder of the overrun.
      write_csr(diee_pkg::CSR_EMIT_UNLIMITED, 32'd1);
      write_csr(diee_pkg::CSR_EMIT_INTERVAL, 32'd7);
      pending_elapsed.push_back(32'd2000);
      pending_elapsed.push_back(TMAX);
      drain();

      // Zero interval: a counted burst repeats one overrun, and an unlimited
      // one repeats it up to the cap.
      write_csr(diee_pkg::CSR_EMIT_INTERVAL, 32'd0);
      write_csr(diee_pkg::CSR_EMIT_UNLIMITED, 32'd0);
      write_csr(diee_pkg::CSR_EMIT_TOTAL, 32'd5);
      pending_elapsed.push_back(32'd30);
      drain();
      write_csr(diee_pkg::CSR_EMIT_UNLIMITED, 32'd1);
      pending_elapsed.push_back(32'd0);
      pending_elapsed.push_back(32'd1000);
      drain();

      // Finished stays low while a delay runs, and rises on the first
      // active update once the limit is zero.
      write_setting(32'd5000, 32'd0, 1'b0, 16'd65535, 1'b0, 32'd300);
      pending_elapsed.push_back(32'd1234);
      pending_elapsed.push_back(32'd4000);
      drain();

      // Random part. Each phase takes a new setting and an idling pattern;
      // the first is a floor setting and the last puts every numeric register
      // at its top value, so the delay counter is not saturated too early.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            write_setting(32'd0, 32'd0, 1'b0, 16'd0, 1'b1, 32'd0);
         end else if (p == RANDOM_PHASES - 1) begin
            write_setting(TMAX, TMAX, 1'b0, 16'hFFFF, 1'b0, TMAX);
         end else begin
            write_setting(
               ($urandom_range(3) == 0) ? $urandom() :
               ($urandom_range(2) == 0) ? 32'd0 : grow_from(delay_count, 3000),
               ($urandom_range(3) == 0) ? $urandom() :
               ($urandom_range(3) == 0) ? TMAX : grow_from(life_count, 20000),
               1'($urandom_range(1)),
               ($urandom_range(4) == 0) ? 16'($urandom()) :
               ($urandom_range(3) == 0) ? 16'd1 : 16'($urandom_range(2, 40)),
               1'($urandom_range(1)),
               ($urandom_range(5) == 0) ? $urandom() :
               ($urandom_range(5) == 0) ? 32'd0 : 32'($urandom_range(1, 50)));
         end
         idle_mode = idle_mode_type'(p % 4);
         for (k = 0; k < PHASE_ITEMS; k++)
            pending_elapsed.push_back(pick_elapsed());
         // Mid-run, the receiver backs off for a long stretch while the
         // sender keeps offering beats.
         if (p == RANDOM_PHASES / 2) hold_asks++;
         drain();
      end

      $display("Ran %0d updates over %0d register settings and four idling patterns.",
               updates_taken, settings_used);
      $display("Checked %0d response beats: %0d emit events, %0d with finished set.",
               beats_checked, emit_beats, finished_beats);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
